@@ rtl/zsse_pkg.sv @@
`timescale 1ns / 1ps
// zsse_pkg: types and constants shared by the zlib stored-stream encoder
// no dependencies; imported by every module of the encoder

package zsse_pkg;

    localparam int unsigned MAX_BLOCK_LEN = 65535;
    localparam logic [16:0] ADLER_MOD     = 17'd65521;
    localparam logic [16:0] BLOCK_MAX     = 17'(MAX_BLOCK_LEN);

    localparam logic [7:0] ZLIB_CMF     = 8'h78;
    localparam logic [7:0] ZLIB_FLG     = 8'h01;
    localparam logic [7:0] BFINAL_SET   = 8'h01;
    localparam logic [7:0] BFINAL_CLEAR = 8'h00;

    // one accepted payload byte, classified by the front end
    typedef struct packed {
        logic        zhdr;      // zlib header precedes this byte
        logic        blkhdr;    // stored block header precedes this byte
        logic        fin;       // block header marks the final block
        logic [15:0] blen;      // LEN of the block that starts here
        logic [7:0]  data;
        logic        trailer;   // adler-32 follows this byte
        logic [15:0] sum_high;
        logic [15:0] sum_low;
    } cmd_t;

    // output sequence positions of one command
    typedef enum logic [11:0] {
        ST_ZH0   = 12'b0000_0000_0001,
        ST_ZH1   = 12'b0000_0000_0010,
        ST_BFIN  = 12'b0000_0000_0100,
        ST_LEN0  = 12'b0000_0000_1000,
        ST_LEN1  = 12'b0000_0001_0000,
        ST_NLEN0 = 12'b0000_0010_0000,
        ST_NLEN1 = 12'b0000_0100_0000,
        ST_DATA  = 12'b0000_1000_0000,
        ST_ADL0  = 12'b0001_0000_0000,
        ST_ADL1  = 12'b0010_0000_0000,
        ST_ADL2  = 12'b0100_0000_0000,
        ST_ADL3  = 12'b1000_0000_0000
    } step_t;

endpackage

@@ rtl/zsse_front.sv @@
`timescale 1ns / 1ps
// zsse_front: accepts payload bytes, tracks stream and block position and
// the running adler-32, and issues one command per byte; uses zsse_pkg

module zsse_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [31:0]          cfg_data,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    output zsse_pkg::cmd_t       cmd
);
    import zsse_pkg::*;

    logic [31:0] stream_length_reg;
    logic [32:0] bytes_consumed_reg, bytes_consumed_next;
    logic [15:0] block_fill_reg, block_fill_next;
    logic [15:0] sum_low_reg, sum_low_next;
    logic [15:0] sum_high_reg, sum_high_next;

    logic [32:0] eff_len;
    logic [32:0] remaining;
    logic [32:0] consumed_inc;
    logic [15:0] fill_inc;
    logic [16:0] low_add, high_add;
    logic [15:0] low_mod;
    logic        ended;

    // a length of zero means 2^32 bytes
    assign eff_len   = {(stream_length_reg == 32'd0), stream_length_reg};
    assign remaining = (eff_len > bytes_consumed_reg) ? (eff_len - bytes_consumed_reg)
                                                      : 33'd1;

    assign consumed_inc = bytes_consumed_reg + 33'd1;
    assign fill_inc     = block_fill_reg + 16'd1;
    assign ended        = (consumed_inc >= eff_len);

    // sums stay below the modulus, so one conditional subtract each
    assign low_add  = {1'b0, sum_low_reg} + {9'd0, data_byte};
    assign low_mod  = (low_add >= ADLER_MOD) ? 16'(low_add - ADLER_MOD) : low_add[15:0];
    assign high_add = {1'b0, sum_high_reg} + {1'b0, low_mod};

    always_comb
    begin
        cmd.zhdr     = (bytes_consumed_reg == 33'd0) && (block_fill_reg == 16'd0);
        cmd.blkhdr   = (block_fill_reg == 16'd0);
        cmd.fin      = (remaining <= {16'd0, BLOCK_MAX});
        cmd.blen     = (remaining < {16'd0, BLOCK_MAX}) ? remaining[15:0] : BLOCK_MAX[15:0];
        cmd.data     = data_byte;
        cmd.trailer  = ended;
        cmd.sum_low  = low_mod;
        cmd.sum_high = (high_add >= ADLER_MOD) ? 16'(high_add - ADLER_MOD) : high_add[15:0];
    end

    always_comb
    begin
        bytes_consumed_next = bytes_consumed_reg;
        block_fill_next     = block_fill_reg;
        sum_low_next        = sum_low_reg;
        sum_high_next       = sum_high_reg;
        if (accept)
        begin
            if (ended)
            begin
                bytes_consumed_next = 33'd0;
                block_fill_next     = 16'd0;
                sum_low_next        = 16'd1;
                sum_high_next       = 16'd0;
            end
            else
            begin
                bytes_consumed_next = consumed_inc;
                block_fill_next     = ({1'b0, fill_inc} >= BLOCK_MAX) ? 16'd0 : fill_inc;
                sum_low_next        = cmd.sum_low;
                sum_high_next       = cmd.sum_high;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg  <= 32'd1;
            bytes_consumed_reg <= 33'd0;
            block_fill_reg     <= 16'd0;
            sum_low_reg        <= 16'd1;
            sum_high_reg       <= 16'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                stream_length_reg <= cfg_data;
            end
            bytes_consumed_reg <= bytes_consumed_next;
            block_fill_reg     <= block_fill_next;
            sum_low_reg        <= sum_low_next;
            sum_high_reg       <= sum_high_next;
        end
    end

endmodule

@@ rtl/zsse_cmd_fifo.sv @@
`timescale 1ns / 1ps
// zsse_cmd_fifo: two-entry command queue between front end and back end
// uses zsse_pkg for the command type

module zsse_cmd_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  zsse_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output zsse_pkg::cmd_t head_cmd
);
    import zsse_pkg::*;

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/zsse_back.sv @@
`timescale 1ns / 1ps
// zsse_back: expands each queued command into its zlib stream bytes and
// drives the registered output stream; uses zsse_pkg

module zsse_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  zsse_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic           m_tuser
);
    import zsse_pkg::*;

    step_t       step_reg, step_next;
    logic        started_reg, started_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;

    step_t       cur_step, first_step, adv_step;
    logic [7:0]  cur_byte;
    logic [15:0] nlen;
    logic        cur_last;
    logic        emit;

    assign nlen = ~head_cmd.blen;
    assign emit = head_valid && (!valid_reg || m_tready);
    assign pop  = emit && cur_last;

    always_comb
    begin
        if (head_cmd.zhdr)
        begin
            first_step = ST_ZH0;
        end
        else if (head_cmd.blkhdr)
        begin
            first_step = ST_BFIN;
        end
        else
        begin
            first_step = ST_DATA;
        end
        cur_step = started_reg ? step_reg : first_step;
    end

    always_comb
    begin
        cur_byte = head_cmd.data;
        adv_step = ST_DATA;
        cur_last = 1'b0;
        unique case (cur_step)
            ST_ZH0:
            begin
                cur_byte = ZLIB_CMF;
                adv_step = ST_ZH1;
            end
            ST_ZH1:
            begin
                cur_byte = ZLIB_FLG;
                adv_step = ST_BFIN;
            end
            ST_BFIN:
            begin
                cur_byte = head_cmd.fin ? BFINAL_SET : BFINAL_CLEAR;
                adv_step = ST_LEN0;
            end
            ST_LEN0:
            begin
                cur_byte = head_cmd.blen[7:0];
                adv_step = ST_LEN1;
            end
            ST_LEN1:
            begin
                cur_byte = head_cmd.blen[15:8];
                adv_step = ST_NLEN0;
            end
            ST_NLEN0:
            begin
                cur_byte = nlen[7:0];
                adv_step = ST_NLEN1;
            end
            ST_NLEN1:
            begin
                cur_byte = nlen[15:8];
                adv_step = ST_DATA;
            end
            ST_DATA:
            begin
                cur_byte = head_cmd.data;
                adv_step = ST_ADL0;
                cur_last = !head_cmd.trailer;
            end
            ST_ADL0:
            begin
                cur_byte = head_cmd.sum_high[15:8];
                adv_step = ST_ADL1;
            end
            ST_ADL1:
            begin
                cur_byte = head_cmd.sum_high[7:0];
                adv_step = ST_ADL2;
            end
            ST_ADL2:
            begin
                cur_byte = head_cmd.sum_low[15:8];
                adv_step = ST_ADL3;
            end
            ST_ADL3:
            begin
                cur_byte = head_cmd.sum_low[7:0];
                adv_step = ST_ZH0;
                cur_last = 1'b1;
            end
            default:
            begin
                cur_byte = head_cmd.data;
                adv_step = ST_DATA;
                cur_last = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        step_next    = step_reg;
        started_next = started_reg;
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        done_next    = done_reg;
        if (emit)
        begin
            valid_next   = 1'b1;
            byte_next    = cur_byte;
            last_next    = cur_last;
            done_next    = (cur_step == ST_ADL3);
            started_next = !cur_last;
            step_next    = adv_step;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_DATA;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

@@ rtl/zlib_stored_stream_encoder_core.sv @@
`timescale 1ns / 1ps
// zlib_stored_stream_encoder_core: top level of the zlib stored-stream encoder
// depends on zsse_pkg, zsse_front, zsse_cmd_fifo and zsse_back
//
// usage:
//   cfg_valid/cfg_data set the stream length in bytes (0 means 2^32); cfg_ready
//   is always high. write it only between streams or while the block is idle.
//   s_tdata carries raw payload bytes; m_tdata carries the zlib stream:
//   header 78 01 before the first byte, a 5-byte stored block header at each
//   block start (blocks of up to 65535 bytes), the payload byte, and after the
//   final byte the adler-32 big-endian. m_tlast marks the last byte caused by
//   each input transaction, m_tuser the final trailer byte of a stream.
//   an input byte passes the command queue and the output register before its
//   first output byte. throughput: one output byte per cycle while m_tready is
//   high, so a payload byte gives one byte, a block start six, the first byte
//   eight, the final byte five; the single-byte output register sets the rate.
//   a two-entry command queue parts the input side from the output side, so
//   input is taken while a result waits; when m_tready stays low the queue
//   fills and s_tready drops after at most two more transactions.
//   reset clears the stream position, sets adler low to 1 and high to 0, and
//   the stream length to one byte; each trailer restarts position and sums.

module zlib_stored_stream_encoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,      // stream_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [7:0] out_byte
    output logic        m_tlast,       // run_last
    output logic        m_tuser        // [0] stream_done
);
    import zsse_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic fifo_full;
    logic head_valid;
    logic pop;
    logic accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !fifo_full;
    assign accept    = s_tvalid && !fifo_full;

    zsse_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (s_tdata),
        .cmd       (front_cmd)
    );

    zsse_cmd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_cmd   (front_cmd),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    zsse_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

@@ rtl/zsse_checker.sv @@
`timescale 1ns / 1ps
// zsse_checker: port-level assertions for zlib_stored_stream_encoder_core
// attached to the top level by the bind statement at the end of this file

module zsse_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // the final trailer byte always closes the transaction of its input byte
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("stream_done without run_last");

    // nothing is presented in the cycle after reset
    a_idle_after_reset: assert property (@(posedge clk)
        $past(!rst_n) |-> !m_tvalid)
        else $error("output valid straight after reset");

    a_stall_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    a_stall_holds_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("output payload changed while stalled");

endmodule

bind zlib_stored_stream_encoder_core zsse_checker u_zsse_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
